// ===== hw/rtl/scksb_pkg.sv =====
// Package for the scaled color-key sprite blitter.
// Holds shared widths, codes, the pipeline side-payload type and the color-key test.
// No dependencies.
`default_nettype none

package scksb_pkg;

    localparam int SPRITE_MAX_SIDE_DEF = 64;
    localparam int SCREEN_WIDTH_DEF    = 1024;
    localparam int SCREEN_HEIGHT_DEF   = 768;

    localparam int STORE_DEPTH = 4096;
    localparam int ADDR_W      = 12;
    localparam int COLOR_W     = 32;
    localparam int POS_W       = 13;
    localparam int DEST_W      = 14;
    localparam int SIZE_W      = 11;
    localparam int CFG_W       = 7;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_W-1:0] SPRITE_DIM_RST = 7'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_HEIGHT = 1'b1;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_DRAW = 1'b1;

    localparam logic [7:0] KEY_DARK_LIM     = 8'd10;
    localparam logic [7:0] KEY_RED_MIN      = 8'd253;
    localparam logic [7:0] KEY_RED_TOL      = 8'd2;
    localparam logic [7:0] KEY_ORANGE_R_MIN = 8'd250;
    localparam logic [7:0] KEY_ORANGE_G_LO  = 8'd160;
    localparam logic [7:0] KEY_ORANGE_G_HI  = 8'd175;

    typedef struct packed {
        logic                load;
        logic                emit;
        logic                ovf_x;
        logic                ovf_y;
        logic [DEST_W-1:0]   dx;
        logic [DEST_W-1:0]   dy;
        logic [ADDR_W-1:0]   idx;
        logic [COLOR_W-1:0]  color;
    } t_side;

    function automatic logic key_out(input logic [COLOR_W-1:0] c);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       dark;
        logic       red;
        logic       orange;
        r      = c[23:16];
        g      = c[15:8];
        b      = c[7:0];
        dark   = (r < KEY_DARK_LIM) && (g < KEY_DARK_LIM) && (b < KEY_DARK_LIM);
        red    = (r >= KEY_RED_MIN) && (g <= KEY_RED_TOL) && (b <= KEY_RED_TOL);
        orange = (r >= KEY_ORANGE_R_MIN) && (g >= KEY_ORANGE_G_LO) && (g <= KEY_ORANGE_G_HI);
        return dark || red || orange;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/scksb_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Assumes dividend below divisor * 2**QW; every stage is registered and held by i_en. Uses scksb_pkg.
`default_nettype none

module scksb_div #(
    parameter int PW = 18,
    parameter int QW = 6
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic [PW-1:0]                i_num,
    input  wire logic [scksb_pkg::SIZE_W-1:0] i_den,
    output logic      [QW-1:0]                o_quot
);
    import scksb_pkg::*;

    logic [PW-1:0]     r_rem  [QW];
    logic [SIZE_W-1:0] r_den  [QW];
    logic [QW-1:0]     r_quot [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [PW-1:0]     w_rem;
        logic [SIZE_W-1:0] w_den;
        logic [QW-1:0]     w_quot;
        logic [PW-1:0]     w_trial;
        logic [PW-1:0]     n_rem;
        logic [QW-1:0]     n_quot;

        if (k == 0) begin : g_first
            assign w_rem  = i_num;
            assign w_den  = i_den;
            assign w_quot = '0;
        end else begin : g_next
            assign w_rem  = r_rem[k-1];
            assign w_den  = r_den[k-1];
            assign w_quot = r_quot[k-1];
        end

        assign w_trial = PW'(w_den) << (QW - 1 - k);

        always_comb begin
            n_rem  = w_rem;
            n_quot = w_quot;
            if (w_rem >= w_trial) begin
                n_rem              = w_rem - w_trial;
                n_quot[QW - 1 - k] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_den[k]  <= w_den;
                r_quot[k] <= n_quot;
            end
        end
    end

    assign o_quot = r_quot[QW-1];

endmodule

`default_nettype wire

// ===== hw/rtl/scksb_store.sv =====
// Texel store: single-port 4096 x 32 memory with registered read data.
// One write or one read per enabled cycle. Uses scksb_pkg.
`default_nettype none

module scksb_store (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic                          i_we,
    input  wire logic [scksb_pkg::ADDR_W-1:0]  i_addr,
    input  wire logic [scksb_pkg::COLOR_W-1:0] i_wdata,
    output logic      [scksb_pkg::COLOR_W-1:0] o_rdata
);
    import scksb_pkg::*;

    logic [COLOR_W-1:0] r_mem [STORE_DEPTH];
    logic [COLOR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/scaled_color_key_sprite_blit.sv =====
// Scaled color-key sprite blitter, top level.
// Uses scksb_pkg, scksb_div (one per axis) and scksb_store.
//
// Takes one word per clock while o_stall is low, load or draw, and returns one
// result word per draw with nonzero size, none per load. A word passes through
// the input register, multiply, one divider stage per quotient bit, address
// stage, store read and output register. Loads and draws pass through the same
// store stage in order, so a draw always sees every load accepted before it.
// A two-entry output buffer (output register plus skid) keeps input accepting
// while a result waits; o_stall is registered.
`default_nettype none

module scaled_color_key_sprite_blit #(
    parameter int SPRITE_MAX_SIDE = scksb_pkg::SPRITE_MAX_SIDE_DEF,
    parameter int SCREEN_WIDTH    = scksb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT   = scksb_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,

    input  wire logic                              i_cfg_we,
    input  wire logic [scksb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [scksb_pkg::CFG_W-1:0]       i_cfg_data,

    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic                              i_mode,
    input  wire logic [scksb_pkg::ADDR_W-1:0]      i_texel_index,
    input  wire logic [scksb_pkg::COLOR_W-1:0]     i_texel_color,
    input  wire logic signed [scksb_pkg::POS_W-1:0] i_pos_x,
    input  wire logic signed [scksb_pkg::POS_W-1:0] i_pos_y,
    input  wire logic [scksb_pkg::SIZE_W-1:0]      i_draw_size,
    input  wire logic [scksb_pkg::SIZE_W-1:0]      i_cell_col,
    input  wire logic [scksb_pkg::SIZE_W-1:0]      i_cell_row,

    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic                                   o_write_pixel,
    output logic signed [scksb_pkg::DEST_W-1:0]    o_dest_x,
    output logic signed [scksb_pkg::DEST_W-1:0]    o_dest_y,
    output logic [scksb_pkg::COLOR_W-1:0]          o_pixel_color
);
    import scksb_pkg::*;

    localparam int DW = $clog2(SPRITE_MAX_SIDE + 1);
    localparam int QW = (SPRITE_MAX_SIDE > 1) ? $clog2(SPRITE_MAX_SIDE) : 1;
    localparam int PW = SIZE_W + DW;

    // config
    logic [CFG_W-1:0] r_sprite_width;
    logic [CFG_W-1:0] r_sprite_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sprite_width  <= SPRITE_DIM_RST;
            r_sprite_height <= SPRITE_DIM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SPRITE_WIDTH:  r_sprite_width  <= i_cfg_data;
                CFG_SPRITE_HEIGHT: r_sprite_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [DW-1:0] w_dim_w;
    logic [DW-1:0] w_dim_h;

    always_comb begin
        if (r_sprite_width == '0) begin
            w_dim_w = DW'(1);
        end else if (32'(r_sprite_width) > 32'(SPRITE_MAX_SIDE)) begin
            w_dim_w = DW'(SPRITE_MAX_SIDE);
        end else begin
            w_dim_w = DW'(r_sprite_width);
        end
        if (r_sprite_height == '0) begin
            w_dim_h = DW'(1);
        end else if (32'(r_sprite_height) > 32'(SPRITE_MAX_SIDE)) begin
            w_dim_h = DW'(SPRITE_MAX_SIDE);
        end else begin
            w_dim_h = DW'(r_sprite_height);
        end
    end

    // pipeline enable: everything advances while the skid is empty
    logic r_skid_valid;
    logic w_en;

    assign w_en    = !r_skid_valid;
    assign o_stall = r_skid_valid;

    // stage 1: input register
    logic              r1_valid;
    logic              r1_mode;
    logic [ADDR_W-1:0] r1_idx;
    logic [COLOR_W-1:0] r1_color;
    logic [POS_W-1:0]  r1_px;
    logic [POS_W-1:0]  r1_py;
    logic [SIZE_W-1:0] r1_size;
    logic [SIZE_W-1:0] r1_col;
    logic [SIZE_W-1:0] r1_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_mode  <= i_mode;
            r1_idx   <= i_texel_index;
            r1_color <= i_texel_color;
            r1_px    <= i_pos_x;
            r1_py    <= i_pos_y;
            r1_size  <= i_draw_size;
            r1_col   <= i_cell_col;
            r1_row   <= i_cell_row;
        end
    end

    // stage 2: products, overflow flags, destination
    t_side             n2_side;
    logic              r2_valid;
    t_side             r2_side;
    logic [PW-1:0]     r2_prod_x;
    logic [PW-1:0]     r2_prod_y;
    logic [SIZE_W-1:0] r2_size;

    always_comb begin
        n2_side.load  = (r1_mode == MODE_LOAD);
        n2_side.emit  = (r1_mode == MODE_DRAW) && (r1_size != '0);
        n2_side.ovf_x = (r1_col >= r1_size);
        n2_side.ovf_y = (r1_row >= r1_size);
        n2_side.dx    = {r1_px[POS_W-1], r1_px} + DEST_W'(r1_col);
        n2_side.dy    = {r1_py[POS_W-1], r1_py} + DEST_W'(r1_row);
        n2_side.idx   = r1_idx;
        n2_side.color = r1_color;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_side   <= n2_side;
            r2_prod_x <= PW'(r1_col) * PW'(w_dim_w);
            r2_prod_y <= PW'(r1_row) * PW'(w_dim_h);
            r2_size   <= r1_size;
        end
    end

    // divider stages
    logic [QW-1:0] w_q_x;
    logic [QW-1:0] w_q_y;

    scksb_div #(.PW(PW), .QW(QW)) u_div_x (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r2_prod_x),
        .i_den  (r2_size),
        .o_quot (w_q_x)
    );

    scksb_div #(.PW(PW), .QW(QW)) u_div_y (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r2_prod_y),
        .i_den  (r2_size),
        .o_quot (w_q_y)
    );

    logic  r_dl_valid [QW];
    t_side r_dl_side  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_dl
        logic  w_valid;
        t_side w_side;
        if (k == 0) begin : g_first
            assign w_valid = r2_valid;
            assign w_side  = r2_side;
        end else begin : g_next
            assign w_valid = r_dl_valid[k-1];
            assign w_side  = r_dl_side[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dl_valid[k] <= 1'b0;
            end else if (w_en) begin
                r_dl_valid[k] <= w_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dl_side[k] <= w_side;
            end
        end
    end

    // stage A: clamp, texel address, clipping
    t_side             w_a_side;
    logic [QW-1:0]     w_sx;
    logic [QW-1:0]     w_sy;
    logic [31:0]       w_addr_full;
    logic [DW-1:0]     w_last_w;
    logic [DW-1:0]     w_last_h;
    logic              w_on_x;
    logic              w_on_y;

    assign w_a_side    = r_dl_side[QW-1];
    assign w_last_w    = w_dim_w - DW'(1);
    assign w_last_h    = w_dim_h - DW'(1);
    assign w_sx        = w_a_side.ovf_x ? w_last_w[QW-1:0] : w_q_x;
    assign w_sy        = w_a_side.ovf_y ? w_last_h[QW-1:0] : w_q_y;
    assign w_addr_full = 32'(w_sy) * 32'(SPRITE_MAX_SIDE) + 32'(w_sx);
    assign w_on_x      = !w_a_side.dx[DEST_W-1]
                         && (w_a_side.dx[DEST_W-2:0] < (DEST_W-1)'(SCREEN_WIDTH));
    assign w_on_y      = !w_a_side.dy[DEST_W-1]
                         && (w_a_side.dy[DEST_W-2:0] < (DEST_W-1)'(SCREEN_HEIGHT));

    logic               r3_valid;
    logic               r3_we;
    logic               r3_emit;
    logic               r3_on_screen;
    logic [ADDR_W-1:0]  r3_addr;
    logic [COLOR_W-1:0] r3_wdata;
    logic [DEST_W-1:0]  r3_dx;
    logic [DEST_W-1:0]  r3_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_en) begin
            r3_valid <= r_dl_valid[QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_we        <= w_a_side.load;
            r3_emit      <= w_a_side.emit;
            r3_on_screen <= w_on_x && w_on_y;
            r3_addr      <= w_a_side.load ? w_a_side.idx : w_addr_full[ADDR_W-1:0];
            r3_wdata     <= w_a_side.color;
            r3_dx        <= w_a_side.dx;
            r3_dy        <= w_a_side.dy;
        end
    end

    // stage M: store access
    logic [COLOR_W-1:0] w_rdata;

    scksb_store u_store (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_we    (r3_valid && r3_we),
        .i_addr  (r3_addr),
        .i_wdata (r3_wdata),
        .o_rdata (w_rdata)
    );

    logic              r4_valid;
    logic              r4_emit;
    logic              r4_on_screen;
    logic [DEST_W-1:0] r4_dx;
    logic [DEST_W-1:0] r4_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (w_en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_emit      <= r3_emit;
            r4_on_screen <= r3_on_screen;
            r4_dx        <= r3_dx;
            r4_dy        <= r3_dy;
        end
    end

    // output register and skid
    logic w_res_valid;
    logic w_res_write;
    logic w_take;

    assign w_res_valid = w_en && r4_valid && r4_emit;
    assign w_res_write = r4_on_screen && !key_out(w_rdata);
    assign w_take      = o_valid && !i_stall;

    logic               r_out_valid;
    logic               r_out_write;
    logic [DEST_W-1:0]  r_out_dx;
    logic [DEST_W-1:0]  r_out_dy;
    logic [COLOR_W-1:0] r_out_color;
    logic               r_skid_write;
    logic [DEST_W-1:0]  r_skid_dx;
    logic [DEST_W-1:0]  r_skid_dy;
    logic [COLOR_W-1:0] r_skid_color;

    logic n_out_valid;
    logic n_skid_valid;
    logic n_out_load_res;
    logic n_out_load_skid;
    logic n_skid_load;

    always_comb begin
        n_out_valid     = r_out_valid && !w_take;
        n_skid_valid    = r_skid_valid;
        n_out_load_res  = 1'b0;
        n_out_load_skid = 1'b0;
        n_skid_load     = 1'b0;
        if (w_res_valid) begin
            if (!r_out_valid || w_take) begin
                n_out_valid    = 1'b1;
                n_out_load_res = 1'b1;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_load  = 1'b1;
            end
        end else if (r_skid_valid && w_take) begin
            n_out_valid     = 1'b1;
            n_out_load_skid = 1'b1;
            n_skid_valid    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_out_load_res) begin
            r_out_write <= w_res_write;
            r_out_dx    <= r4_dx;
            r_out_dy    <= r4_dy;
            r_out_color <= w_rdata;
        end else if (n_out_load_skid) begin
            r_out_write <= r_skid_write;
            r_out_dx    <= r_skid_dx;
            r_out_dy    <= r_skid_dy;
            r_out_color <= r_skid_color;
        end
        if (n_skid_load) begin
            r_skid_write <= w_res_write;
            r_skid_dx    <= r4_dx;
            r_skid_dy    <= r4_dy;
            r_skid_color <= w_rdata;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_write_pixel = r_out_write;
    assign o_dest_x      = r_out_dx;
    assign o_dest_y      = r_out_dy;
    assign o_pixel_color = r_out_color;

    // checks
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a word while output register is empty");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_stall) |=> !r_skid_valid)
        else $error("skid word not moved after output was taken");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_stall && !o_valid))
        else $error("output side not idle after reset");

endmodule

`default_nettype wire
